/* sv/tga_rle_pixel_decoder_unit_assert.svh */
// Assertion macros used by the decoder checker.
`ifndef TGA_RLE_PIXEL_DECODER_UNIT_ASSERT_SVH
`define TGA_RLE_PIXEL_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define TGAD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tgad assertion failed");

// Next-cycle implication.
`define TGAD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tgad assertion failed");

`endif

/* sv/tgad_pkg.sv */
// ---------------------------------------------------------------------------
// tgad_pkg
// Types and constants shared by the TGA pixel decoder modules.
// ---------------------------------------------------------------------------
`default_nettype none

package tgad_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_COMPRESSED      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BYTES_PER_PIXEL = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_IDENT_LENGTH    = 3'd4;

   localparam logic [2:0] BPP_WITH_ALPHA = 3'd4;
   localparam logic [2:0] BPP_RESET      = 3'd3;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_OVERRUN   = 2'd1;
   localparam logic [1:0] STATUS_TRUNCATED = 2'd2;

   localparam logic [7:0] RUN_BIAS = 8'd127;

   // One queued item; skip marks an image-ident byte.
   typedef struct packed {
      logic       skip;
      logic       eos;
      logic [7:0] data;
   } item_type;

   typedef struct packed {
      logic        compressed;
      logic        alpha_en;
      logic [31:0] total;
   } cfg_type;

   typedef struct packed {
      logic       load;
      logic [7:0] value;
   } ident_load_type;

   typedef struct packed {
      logic full;
      logic valid;
   } queue_status_type;

endpackage

`default_nettype wire

/* sv/tga_rle_pixel_decoder_unit.sv */
// Takes TGA pixel data (req_ valid/ready) one byte per cycle while the queue has
// room, after the header has been written through the csr_ port, and returns
// pixels on the rsp_ channel with B and R swapped, each RLE run as a single item
// with its repeat count. Sustained rate is one byte per cycle while the result
// register is empty or being taken; with the queue empty and the result register
// free, an accepted byte is first written into the queue and its result is then
// loaded into the result register. The front takes bytes as long as the
// QUEUE_DEPTH-entry queue has room, and the decode stage consumes one queued
// byte per cycle whenever the result register is empty or being taken.
// csr_ready is always high. The width*height product is registered, so it is
// valid in the cycle after the size registers change. Once an item with last
// set is given, further bytes are taken and dropped until reset.
// ---------------------------------------------------------------------------
// tga_rle_pixel_decoder_unit
// TGA truecolor / RLE pixel-data decoder, top level.
// ---------------------------------------------------------------------------
`default_nettype none

module tga_rle_pixel_decoder_unit #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [tgad_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [tgad_pkg::CSR_DATA_W-1:0]   csr_data,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [7:0]                        req_data_byte,
   input  logic                              req_end_of_stream,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [7:0]                        rsp_red,
   output logic [7:0]                        rsp_green,
   output logic [7:0]                        rsp_blue,
   output logic [7:0]                        rsp_alpha,
   output logic [7:0]                        rsp_repeat_count,
   output logic [1:0]                        rsp_status,
   output logic                              rsp_last
);

   tgad_pkg::cfg_type          cfg;
   tgad_pkg::ident_load_type   ident_load;
   tgad_pkg::queue_status_type queue_status;
   tgad_pkg::item_type         push_item;
   tgad_pkg::item_type         pop_item;
   logic                       push;
   logic                       pop_ready;

   tgad_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .cfg        (cfg),
      .ident_load (ident_load)
   );

   tgad_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_end_of_stream (req_end_of_stream),
      .ident_load        (ident_load),
      .queue_status      (queue_status),
      .push              (push),
      .push_item         (push_item)
   );

   tgad_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop_ready (pop_ready),
      .status    (queue_status),
      .pop_item  (pop_item)
   );

   tgad_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .item_valid       (queue_status.valid),
      .item_ready       (pop_ready),
      .item             (pop_item),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_red          (rsp_red),
      .rsp_green        (rsp_green),
      .rsp_blue         (rsp_blue),
      .rsp_alpha        (rsp_alpha),
      .rsp_repeat_count (rsp_repeat_count),
      .rsp_status       (rsp_status),
      .rsp_last         (rsp_last)
   );

endmodule

`default_nettype wire

/* sv/tgad_csr.sv */
// ---------------------------------------------------------------------------
// tgad_csr
// Header registers and the registered pixel total of the image.
// ---------------------------------------------------------------------------
`default_nettype none

module tgad_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tgad_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [tgad_pkg::CSR_DATA_W-1:0]     csr_data,
   output tgad_pkg::cfg_type                   cfg,
   output tgad_pkg::ident_load_type            ident_load
);

   logic        compressed_ff, compressed_in;
   logic [2:0]  bpp_ff, bpp_in;
   logic [15:0] width_ff, width_in;
   logic [15:0] height_ff, height_in;
   logic [31:0] total_ff, total_in;
   logic        wr;

   assign csr_ready = 1'b1;
   assign wr        = csr_valid && csr_ready;

   always_comb begin
      compressed_in    = compressed_ff;
      bpp_in           = bpp_ff;
      width_in         = width_ff;
      height_in        = height_ff;
      ident_load.load  = 1'b0;
      ident_load.value = csr_data[7:0];
      if (wr) begin
         unique case (csr_index)
            tgad_pkg::CSR_COMPRESSED:      compressed_in   = csr_data[0];
            tgad_pkg::CSR_BYTES_PER_PIXEL: bpp_in          = csr_data[2:0];
            tgad_pkg::CSR_IMAGE_WIDTH:     width_in        = csr_data;
            tgad_pkg::CSR_IMAGE_HEIGHT:    height_in       = csr_data;
            tgad_pkg::CSR_IDENT_LENGTH:    ident_load.load = 1'b1;
            default: ;
         endcase
      end
   end

   // product of the size registers, registered into total_ff
   assign total_in = {16'd0, width_ff} * {16'd0, height_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         compressed_ff <= 1'b0;
         bpp_ff        <= tgad_pkg::BPP_RESET;
         width_ff      <= 16'd1;
         height_ff     <= 16'd1;
         total_ff      <= 32'd1;
      end else begin
         compressed_ff <= compressed_in;
         bpp_ff        <= bpp_in;
         width_ff      <= width_in;
         height_ff     <= height_in;
         total_ff      <= total_in;
      end
   end

   assign cfg.compressed = compressed_ff;
   assign cfg.alpha_en   = (bpp_ff == tgad_pkg::BPP_WITH_ALPHA);
   assign cfg.total      = total_ff;

endmodule

`default_nettype wire

/* sv/tgad_front.sv */
// ---------------------------------------------------------------------------
// tgad_front
// Accepts stream bytes and tags the image-ident bytes that are skipped.
// ---------------------------------------------------------------------------
`default_nettype none

module tgad_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [7:0]                    req_data_byte,
   input  logic                          req_end_of_stream,
   input  tgad_pkg::ident_load_type      ident_load,
   input  tgad_pkg::queue_status_type    queue_status,
   output logic                          push,
   output tgad_pkg::item_type            push_item
);

   logic [7:0] ident_rem_ff, ident_rem_in;
   logic       skipping_ff, skipping_in;

   assign req_ready = !queue_status.full;
   assign push      = req_valid && req_ready;

   always_comb begin
      ident_rem_in   = ident_rem_ff;
      skipping_in    = skipping_ff;
      push_item.data = req_data_byte;
      push_item.eos  = req_end_of_stream;
      push_item.skip = 1'b0;
      if (ident_load.load) begin
         ident_rem_in = ident_load.value;
      end else if (push && skipping_ff) begin
         if (ident_rem_ff != 8'd0) begin
            ident_rem_in   = ident_rem_ff - 8'd1;
            push_item.skip = 1'b1;
         end else begin
            // first pixel-data byte: ident field is over for good
            skipping_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ident_rem_ff <= 8'd0;
         skipping_ff  <= 1'b1;
      end else begin
         ident_rem_ff <= ident_rem_in;
         skipping_ff  <= skipping_in;
      end
   end

endmodule

`default_nettype wire

/* sv/tgad_queue.sv */
// ---------------------------------------------------------------------------
// tgad_queue
// Small item queue between the front and the decode back end.
// ---------------------------------------------------------------------------
`default_nettype none

module tgad_queue #(
   parameter int DEPTH = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  tgad_pkg::item_type            push_item,
   input  logic                          pop_ready,
   output tgad_pkg::queue_status_type    status,
   output tgad_pkg::item_type            pop_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   tgad_pkg::item_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.valid = (count_ff != '0);
   assign pop_item     = mem_ff[rd_ptr_ff];
   assign pop          = status.valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

/* sv/tgad_back.sv */
// ---------------------------------------------------------------------------
// tgad_back
// Packet parsing, pixel assembly, pixel count checks and result register.
// ---------------------------------------------------------------------------
`default_nettype none

module tgad_back (
   input  logic                  clock,
   input  logic                  reset,
   input  tgad_pkg::cfg_type     cfg,
   input  logic                  item_valid,
   output logic                  item_ready,
   input  tgad_pkg::item_type    item,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            rsp_red,
   output logic [7:0]            rsp_green,
   output logic [7:0]            rsp_blue,
   output logic [7:0]            rsp_alpha,
   output logic [7:0]            rsp_repeat_count,
   output logic [1:0]            rsp_status,
   output logic                  rsp_last
);

   typedef enum logic [5:0] {
      PH_SKIP   = 6'b000001,
      PH_PLAIN  = 6'b000010,
      PH_HEADER = 6'b000100,
      PH_RAW    = 6'b001000,
      PH_RUN    = 6'b010000,
      PH_DONE   = 6'b100000
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [1:0]  idx_ff, idx_in;
   logic [23:0] colour_ff, colour_in;
   logic [7:0]  rem_ff, rem_in;
   logic [31:0] done_ff, done_in;

   logic        valid_ff, valid_in;
   logic [7:0]  red_ff, red_in, green_ff, green_in, blue_ff, blue_in;
   logic [7:0]  alpha_ff, alpha_in, count_ff, count_in;
   logic [1:0]  status_ff, status_in;
   logic        last_ff, last_in;

   logic        pop, load, failed, pixel_end, full;
   logic [7:0]  cnt;
   logic [32:0] sum;

   assign item_ready = !valid_ff || rsp_ready;
   assign pop        = item_valid && item_ready;

   always_comb begin
      phase_in  = phase_ff;
      idx_in    = idx_ff;
      colour_in = colour_ff;
      rem_in    = rem_ff;
      done_in   = done_ff;
      load      = 1'b0;
      failed    = 1'b0;
      pixel_end = 1'b0;
      full      = 1'b0;
      cnt       = 8'd1;
      sum       = {1'b0, done_ff} + 33'd1;
      red_in    = red_ff;
      green_in  = green_ff;
      blue_in   = blue_ff;
      alpha_in  = alpha_ff;
      count_in  = count_ff;
      status_in = status_ff;
      last_in   = last_ff;

      if (pop && phase_ff != PH_DONE) begin
         if (phase_ff == PH_SKIP && !item.skip) begin
            phase_in = cfg.compressed ? PH_HEADER : PH_PLAIN;
            idx_in   = 2'd0;
         end
         if (!item.skip) begin
            if (phase_in == PH_HEADER) begin
               if (!item.data[7]) begin
                  phase_in = PH_RAW;
                  rem_in   = item.data + 8'd1;
               end else begin
                  phase_in = PH_RUN;
                  rem_in   = item.data - tgad_pkg::RUN_BIAS;
               end
               idx_in = 2'd0;
            end else begin
               if (idx_in == 2'd0) begin
                  colour_in = '0;
               end
               unique case (idx_in)
                  2'd0:    colour_in[7:0]   = item.data;
                  2'd1:    colour_in[15:8]  = item.data;
                  2'd2:    colour_in[23:16] = item.data;
                  default: ;
               endcase
               pixel_end = (idx_in == 2'd3) || (!cfg.alpha_en && idx_in == 2'd2);
               if (!pixel_end) begin
                  idx_in = idx_in + 2'd1;
               end else begin
                  cnt      = (phase_in == PH_RUN) ? rem_in : 8'd1;
                  sum      = {1'b0, done_ff} + {25'd0, cnt};
                  idx_in   = 2'd0;
                  load     = 1'b1;
                  red_in   = colour_in[23:16];
                  green_in = colour_in[15:8];
                  blue_in  = colour_in[7:0];
                  alpha_in = cfg.alpha_en ? item.data : 8'd0;
                  count_in = cnt;
                  if (sum > {1'b0, cfg.total}) begin
                     status_in = tgad_pkg::STATUS_OVERRUN;
                     last_in   = 1'b1;
                     phase_in  = PH_DONE;
                     failed    = 1'b1;
                  end else begin
                     done_in = sum[31:0];
                     full    = (sum[31:0] == cfg.total);
                     if (phase_in == PH_RAW) begin
                        rem_in = rem_in - 8'd1;
                        if (rem_in == 8'd0) begin
                           phase_in = full ? PH_DONE : PH_HEADER;
                        end
                     end else if (phase_in == PH_RUN) begin
                        rem_in   = 8'd0;
                        phase_in = full ? PH_DONE : PH_HEADER;
                     end else if (full) begin
                        phase_in = PH_DONE;
                     end
                     status_in = tgad_pkg::STATUS_OK;
                     last_in   = (phase_in == PH_DONE);
                  end
               end
            end
         end
         // early end of stream wins over a pixel finished on the same byte
         if (item.eos && !failed && phase_in != PH_DONE) begin
            load      = 1'b1;
            red_in    = 8'd0;
            green_in  = 8'd0;
            blue_in   = 8'd0;
            alpha_in  = 8'd0;
            count_in  = 8'd1;
            status_in = tgad_pkg::STATUS_TRUNCATED;
            last_in   = 1'b1;
            phase_in  = PH_DONE;
         end
      end

      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_SKIP;
         idx_ff    <= 2'd0;
         colour_ff <= '0;
         rem_ff    <= 8'd0;
         done_ff   <= 32'd0;
         valid_ff  <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         idx_ff    <= idx_in;
         colour_ff <= colour_in;
         rem_ff    <= rem_in;
         done_ff   <= done_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      red_ff    <= red_in;
      green_ff  <= green_in;
      blue_ff   <= blue_in;
      alpha_ff  <= alpha_in;
      count_ff  <= count_in;
      status_ff <= status_in;
      last_ff   <= last_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_red          = red_ff;
   assign rsp_green        = green_ff;
   assign rsp_blue         = blue_ff;
   assign rsp_alpha        = alpha_ff;
   assign rsp_repeat_count = count_ff;
   assign rsp_status       = status_ff;
   assign rsp_last         = last_ff;

endmodule

`default_nettype wire

/* sv/tgad_checker.sv */
// ---------------------------------------------------------------------------
// tgad_checker
// Port-level checks on the decoder result channel.
// ---------------------------------------------------------------------------
`default_nettype none

`include "tga_rle_pixel_decoder_unit_assert.svh"

module tgad_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_red,
   input logic [7:0] rsp_green,
   input logic [7:0] rsp_blue,
   input logic [7:0] rsp_alpha,
   input logic [7:0] rsp_repeat_count,
   input logic [1:0] rsp_status,
   input logic       rsp_last
);

   `TGAD_ASSERT_NEXT(a_reset_empties, clock, 1'b0, reset, !rsp_valid)

   `TGAD_ASSERT_NEXT(a_stall_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_red) && $stable(rsp_green) && $stable(rsp_blue) && $stable(rsp_alpha) && $stable(rsp_repeat_count) && $stable(rsp_status) && $stable(rsp_last))

   `TGAD_ASSERT_IMPLY(a_error_is_last, clock, reset, rsp_valid && rsp_status != tgad_pkg::STATUS_OK, rsp_last)

   `TGAD_ASSERT_IMPLY(a_trunc_blank, clock, reset, rsp_valid && rsp_status == tgad_pkg::STATUS_TRUNCATED, rsp_red == 8'd0 && rsp_green == 8'd0 && rsp_blue == 8'd0 && rsp_alpha == 8'd0 && rsp_repeat_count == 8'd1)

   `TGAD_ASSERT_IMPLY(a_item_legal, clock, reset, rsp_valid, rsp_repeat_count != 8'd0 && (rsp_status == tgad_pkg::STATUS_OK || rsp_status == tgad_pkg::STATUS_OVERRUN || rsp_status == tgad_pkg::STATUS_TRUNCATED))

endmodule

bind tga_rle_pixel_decoder_unit tgad_checker u_tgad_checker (.*);

`default_nettype wire

/* verif/testbench.sv */
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the TGA truecolor / RLE pixel-data decoder.
// A byte-level model of the decoder predicts every result item. The checker
// compares each returned item field by field in order. Stimulus is a
// run-length stream: directed packets first, then random raw and run packets
// with stray bytes mixed in, and random gaps and stalls on both channels. Size,
// pixel-format and mode registers are rewritten between bursts while the
// decoder is idle. The stream closes with an overrun, an exact fill, a zero
// size or a truncated stream.
// ---------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLOCK_PERIOD = 20;
   localparam int RANDOM_BYTES = 700;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int IDLE_PCT     = 21;

   typedef enum logic [5:0] {
      PH_SKIP   = 6'b000001,
      PH_PLAIN  = 6'b000010,
      PH_HEADER = 6'b000100,
      PH_RAW    = 6'b001000,
      PH_RUN    = 6'b010000,
      PH_DONE   = 6'b100000
   } decode_phase_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic [7:0] repeat_count;
      logic [1:0] status;
      logic       last;
   } pixel_type;

   // Tracks the decoder byte by byte and holds the pixels still owed.
   class pixel_checker;
      pixel_type        pending_pixels[$];
      int               errors;
      int               checked;
      int               runs_seen;
      logic [1:0]       end_status;
      logic             compressed_r;
      logic [2:0]       bpp_r;
      logic [15:0]      width_r;
      logic [15:0]      height_r;
      logic [7:0]       ident_len_r;
      decode_phase_type phase;
      logic [7:0]       ident_left;
      logic             packet_run;
      logic [7:0]       packet_left;
      logic [1:0]       byte_idx;
      logic [23:0]      colour;
      logic [31:0]      pixels_done;

      function new();
         compressed_r = 1'b0;
         bpp_r        = tgad_pkg::BPP_RESET;
         width_r      = 16'd1;
         height_r     = 16'd1;
         ident_len_r  = 8'd0;
         phase        = PH_SKIP;
         ident_left   = 8'd0;
         packet_run   = 1'b0;
         packet_left  = 8'd0;
         byte_idx     = 2'd0;
         colour       = 24'd0;
         pixels_done  = 32'd0;
         errors       = 0;
         checked      = 0;
         runs_seen    = 0;
         end_status   = tgad_pkg::STATUS_OK;
      endfunction

      function void write_register(logic [tgad_pkg::CSR_INDEX_W-1:0] idx,
                                   logic [tgad_pkg::CSR_DATA_W-1:0] value);
         case (idx)
            tgad_pkg::CSR_COMPRESSED:      compressed_r = value[0];
            tgad_pkg::CSR_BYTES_PER_PIXEL: bpp_r = value[2:0];
            tgad_pkg::CSR_IMAGE_WIDTH:     width_r = value;
            tgad_pkg::CSR_IMAGE_HEIGHT:    height_r = value;
            tgad_pkg::CSR_IDENT_LENGTH: begin
               ident_len_r = value[7:0];
               ident_left  = value[7:0];
            end
            default: ;
         endcase
      endfunction

      function int pixel_bytes();
         return (bpp_r == tgad_pkg::BPP_WITH_ALPHA) ? 4 : 3;
      endfunction

      function int pending();
         return pending_pixels.size();
      endfunction

      function bit finished();
         return phase == PH_DONE;
      endfunction

      function void accept_byte(logic [7:0] data, logic eos);
         logic [63:0] total;
         logic        consumed;
         logic        failed;
         logic        produced;
         logic        full;
         int          bpp;
         int          idx;
         logic [7:0]  cnt;
         pixel_type   px;
         total    = {48'd0, width_r} * {48'd0, height_r};
         consumed = 1'b0;
         failed   = 1'b0;
         produced = 1'b0;
         px       = '0;
         if (phase == PH_DONE)
            return;
         if (phase == PH_SKIP) begin
            if (ident_left != 0) begin
               ident_left--;
               consumed = 1'b1;
            end else begin
               // mode is latched on the first byte past the ident field
               phase    = compressed_r ? PH_HEADER : PH_PLAIN;
               byte_idx = 2'd0;
            end
         end
         if (!consumed) begin
            if (phase == PH_HEADER) begin
               packet_run  = data[7];
               packet_left = data[7] ? data - tgad_pkg::RUN_BIAS : data + 8'd1;
               phase       = data[7] ? PH_RUN : PH_RAW;
               byte_idx    = 2'd0;
            end else begin
               bpp = pixel_bytes();
               idx = int'(byte_idx);
               if (idx == 0)
                  colour = 24'd0;
               if (idx < 3)
                  colour = colour | ({16'd0, data} << (8 * idx));
               if (idx + 1 < bpp) begin
                  byte_idx = 2'(idx + 1);
               end else begin
                  cnt             = (phase == PH_RUN) ? packet_left : 8'd1;
                  px.red          = colour[23:16];
                  px.green        = colour[15:8];
                  px.blue         = colour[7:0];
                  px.alpha        = (bpp == 4) ? data : 8'd0;
                  px.repeat_count = cnt;
                  byte_idx        = 2'd0;
                  if ({32'd0, pixels_done} + {56'd0, cnt} > total) begin
                     px.status = tgad_pkg::STATUS_OVERRUN;
                     px.last   = 1'b1;
                     phase     = PH_DONE;
                     failed    = 1'b1;
                  end else begin
                     pixels_done = pixels_done + {24'd0, cnt};
                     full = ({32'd0, pixels_done} == total);
                     if (phase == PH_RAW) begin
                        packet_left--;
                        if (packet_left == 0)
                           phase = full ? PH_DONE : PH_HEADER;
                     end else if (phase == PH_RUN) begin
                        packet_left = 8'd0;
                        phase = full ? PH_DONE : PH_HEADER;
                     end else if (full) begin
                        phase = PH_DONE;
                     end
                     px.status = tgad_pkg::STATUS_OK;
                     px.last   = (phase == PH_DONE);
                  end
                  produced = 1'b1;
               end
            end
         end
         // truncation wins over a pixel finished on the same byte
         if (eos && !failed && phase != PH_DONE) begin
            px              = '0;
            px.repeat_count = 8'd1;
            px.status       = tgad_pkg::STATUS_TRUNCATED;
            px.last         = 1'b1;
            phase           = PH_DONE;
            produced        = 1'b1;
         end
         if (produced)
            pending_pixels.push_back(px);
      endfunction

      function void compare(string field, int want, int got);
         if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", field, want, got);
            errors++;
         end
      endfunction

      function void check_pixel(pixel_type got);
         pixel_type want;
         if (pending_pixels.size() == 0) begin
            $error("unexpected item: nothing pending (status %0d, last %0d)",
               got.status, got.last);
            errors++;
            return;
         end
         want = pending_pixels.pop_front();
         checked++;
         if (got.repeat_count > 1)
            runs_seen++;
         if (got.last)
            end_status = got.status;
         compare("red", int'(want.red), int'(got.red));
         compare("green", int'(want.green), int'(got.green));
         compare("blue", int'(want.blue), int'(got.blue));
         compare("alpha", int'(want.alpha), int'(got.alpha));
         compare("repeat_count", int'(want.repeat_count), int'(got.repeat_count));
         compare("status", int'(want.status), int'(got.status));
         compare("last", int'(want.last), int'(got.last));
      endfunction
   endclass

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [tgad_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [tgad_pkg::CSR_DATA_W-1:0]  csr_data = '0;
   logic                             req_valid = 1'b0;
   logic                             req_ready;
   logic [7:0]                       req_data_byte = 8'd0;
   logic                             req_end_of_stream = 1'b0;
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b0;
   logic [7:0]                       rsp_red;
   logic [7:0]                       rsp_green;
   logic [7:0]                       rsp_blue;
   logic [7:0]                       rsp_alpha;
   logic [7:0]                       rsp_repeat_count;
   logic [1:0]                       rsp_status;
   logic                             rsp_last;

   bit           steady = 1'b0;
   int           bytes_sent = 0;
   int           cycles = 0;
   pixel_checker sb = new();

   tga_rle_pixel_decoder_unit DUT (.*);

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_pixel({rsp_red, rsp_green, rsp_blue, rsp_alpha, rsp_repeat_count,
            rsp_status, rsp_last});
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 9))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // valid stays high after acceptance; the next gap or go_idle lowers it
   task automatic send_byte(logic [7:0] data, logic eos);
      while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_data_byte     <= data;
      req_end_of_stream <= eos;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      sb.accept_byte(data, eos);
      bytes_sent++;
   endtask

   task automatic send_seq(input logic [7:0] seq[$]);
      foreach (seq[i])
         send_byte(seq[i], 1'b0);
   endtask

   task automatic send_pixels(int n_pixels);
      repeat (n_pixels)
         repeat (sb.pixel_bytes())
            send_byte(pick_byte(), 1'b0);
   endtask

   task automatic send_packet();
      int         kind;
      logic [7:0] header;
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
         // stray byte, shifts the packet framing
         send_byte(pick_byte(), 1'b0);
      end else if (kind < 50) begin
         header = 8'($urandom_range(128, 255));
         send_byte(header, 1'b0);
         send_pixels(1);
      end else begin
         header = (kind < 54) ? 8'($urandom_range(0, 127)) : 8'($urandom_range(0, 7));
         send_byte(header, 1'b0);
         send_pixels(int'(header) + 1);
      end
   endtask

   task automatic write_csr(logic [tgad_pkg::CSR_INDEX_W-1:0] idx,
                            logic [tgad_pkg::CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      sb.write_register(idx, value);
   endtask

   task automatic end_writes();
      csr_valid <= 1'b0;
      repeat (4) @(posedge clock);
   endtask

   // queue and decode stage may still hold bytes that yield no item
   task automatic go_idle();
      req_valid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic retune();
      case ($urandom_range(0, 4))
         0:       write_csr(tgad_pkg::CSR_COMPRESSED, 16'($urandom_range(0, 1)));
         1:       write_csr(tgad_pkg::CSR_IDENT_LENGTH, 16'($urandom_range(0, 255)));
         2:       write_csr(tgad_pkg::CSR_IMAGE_WIDTH, 16'($urandom_range(32768, 65535)));
         3:       write_csr(tgad_pkg::CSR_IMAGE_HEIGHT, 16'($urandom_range(32768, 65535)));
         default: ;
      endcase
      if ($urandom_range(0, 3) == 0)
         write_csr(tgad_pkg::CSR_BYTES_PER_PIXEL, 16'($urandom_range(0, 7)));
      else
         write_csr(tgad_pkg::CSR_BYTES_PER_PIXEL, 16'($urandom_range(3, 4)));
      end_writes();
   endtask

   task automatic finish_image();
      int          how;
      logic [31:0] done_px;
      go_idle();
      how     = $urandom_range(0, 2);
      done_px = sb.pixels_done;
      case (how)
         0: begin
            // shrink the image to around what is decoded: exact fill or overrun
            if (done_px + 4 <= 65535) begin
               write_csr(tgad_pkg::CSR_IMAGE_WIDTH, 16'(done_px + $urandom_range(1, 4)));
               write_csr(tgad_pkg::CSR_IMAGE_HEIGHT, 16'd1);
            end else begin
               write_csr(tgad_pkg::CSR_IMAGE_WIDTH, 16'd65535);
               write_csr(tgad_pkg::CSR_IMAGE_HEIGHT, 16'(done_px / 65535));
            end
            end_writes();
            while (!sb.finished())
               send_packet();
         end
         1: begin
            write_csr($urandom_range(0, 1) ? tgad_pkg::CSR_IMAGE_WIDTH
                                           : tgad_pkg::CSR_IMAGE_HEIGHT, 16'd0);
            end_writes();
            while (!sb.finished())
               send_packet();
         end
         default: begin
            if ($urandom_range(0, 1)) begin
               // end of stream on the byte that completes a run colour
               send_byte(8'd133, 1'b0);
               repeat (sb.pixel_bytes() - 1)
                  send_byte(pick_byte(), 1'b0);
               send_byte(pick_byte(), 1'b1);
            end else begin
               repeat ($urandom_range(0, 10))
                  send_byte(pick_byte(), 1'b0);
               send_byte(pick_byte(), 1'b1);
            end
         end
      endcase
      // decoding has ended: these must vanish
      repeat (4)
         send_byte(pick_byte(), 1'($urandom_range(0, 1)));
   endtask

   initial begin
      int start;
      int next_cfg;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      write_csr(tgad_pkg::CSR_COMPRESSED, 16'd1);
      write_csr(tgad_pkg::CSR_BYTES_PER_PIXEL, 16'd4);
      write_csr(tgad_pkg::CSR_IMAGE_WIDTH, 16'd65535);
      write_csr(tgad_pkg::CSR_IMAGE_HEIGHT, 16'd65535);
      write_csr(tgad_pkg::CSR_IDENT_LENGTH, 16'd255);
      end_writes();
      repeat (255)
         send_byte(8'($urandom_range(0, 255)), 1'b0);

      // longest run, shortest run, single raw pixel, with alpha
      send_seq('{8'd255, 8'h00, 8'hFF, 8'h80, 8'hFF});
      send_seq('{8'd128, 8'hFF, 8'h00, 8'h01, 8'h00});
      send_seq('{8'd0, 8'hAA, 8'h55, 8'hFF, 8'h00});
      go_idle();
      // mode is already latched, so clearing compressed changes nothing
      write_csr(tgad_pkg::CSR_COMPRESSED, 16'd0);
      write_csr(tgad_pkg::CSR_BYTES_PER_PIXEL, 16'd3);
      write_csr(tgad_pkg::CSR_IDENT_LENGTH, 16'd0);
      end_writes();
      send_seq('{8'd1, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00});
      send_seq('{8'd200, 8'h12, 8'h34, 8'h56});

      start    = bytes_sent;
      next_cfg = start + 150;
      while (bytes_sent < start + RANDOM_BYTES) begin
         steady = (bytes_sent - start >= 300) && (bytes_sent - start < 450);
         if (bytes_sent >= next_cfg) begin
            go_idle();
            retune();
            next_cfg = bytes_sent + 150 + $urandom_range(0, 100);
         end
         send_packet();
      end
      steady = 1'b0;

      finish_image();
      go_idle();

      $display("Sent %0d bytes (255 ident): %0d items checked, %0d runs, %0d pixels decoded",
         bytes_sent, sb.checked, sb.runs_seen, sb.pixels_done);
      $display("Image closed with status %0d after mid-stream size and format rewrites",
         sb.end_status);
      if (sb.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
